@@ sv/tkmm_pkg.sv @@
`timescale 1ns / 1ps

package tkmm_pkg;

  localparam int MAX_KEY_DIM  = 32;
  localparam int MAX_FILE_DIM = 64;
  localparam int TILE_ALIGN   = 8;
  localparam int KEY_DEPTH    = MAX_KEY_DIM * MAX_KEY_DIM;
  localparam int FILE_DEPTH   = MAX_FILE_DIM * MAX_FILE_DIM;
  localparam int KEY_AW       = $clog2(KEY_DEPTH);
  localparam int FILE_AW      = $clog2(FILE_DEPTH);
  localparam int KEY_DIM_W    = 6;
  localparam int FILE_DIM_W   = 7;
  localparam int VALUE_W      = 16;
  localparam int RESULT_W     = 38;
  localparam int PROD_W       = 2 * VALUE_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic CFG_KEY_DIM  = 1'b0;
  localparam logic CFG_FILE_DIM = 1'b1;

  typedef enum logic [1:0] {
    CMD_KEY_LOAD  = 2'd0,
    CMD_FILE_LOAD = 2'd1,
    CMD_FETCH     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_KEY,
    JOB_FILE,
    JOB_FETCH
  } job_kind_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROWCOL,
    BK_SPAN,
    BK_CHECK,
    BK_BAND,
    BK_BASE,
    BK_MAC,
    BK_DRAIN,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic                       last;
  } result_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic [FILE_AW-1:0]         addr;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
    logic                       empty;
  } job_t;

  function automatic logic [KEY_DIM_W-1:0] eff_key(input logic [KEY_DIM_W-1:0] k);
    logic [KEY_DIM_W-1:0] c;
    c = (k > KEY_DIM_W'(MAX_KEY_DIM)) ? KEY_DIM_W'(MAX_KEY_DIM) : k;
    return c - (c % KEY_DIM_W'(TILE_ALIGN));
  endfunction

  function automatic logic [FILE_DIM_W-1:0] eff_file(input logic [FILE_DIM_W-1:0] f);
    return (f > FILE_DIM_W'(MAX_FILE_DIM)) ? FILE_DIM_W'(MAX_FILE_DIM) : f;
  endfunction

endpackage

@@ sv/tkmm_front.sv @@
`timescale 1ns / 1ps

module tkmm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  tkmm_pkg::item_t                 item,
  input  logic [tkmm_pkg::KEY_DIM_W-1:0]  k_dim,
  input  logic [tkmm_pkg::FILE_DIM_W-1:0] f_dim,
  input  logic                            queue_full,
  output logic                            push,
  output tkmm_pkg::job_t                  job
);
  import tkmm_pkg::*;

  logic [KEY_AW-1:0]  kpos, kpos_next, kp;
  logic [FILE_AW-1:0] fpos, fpos_next, fp;
  logic [FILE_AW-1:0] xpos, xpos_next, xp;
  logic [KEY_AW:0]    klim, kn;
  logic [FILE_AW:0]   flim, fn, xn;
  logic               accept;

  assign klim = {{(KEY_AW+1-KEY_DIM_W){1'b0}}, k_dim} * {{(KEY_AW+1-KEY_DIM_W){1'b0}}, k_dim};
  assign flim = {{(FILE_AW+1-FILE_DIM_W){1'b0}}, f_dim}
              * {{(FILE_AW+1-FILE_DIM_W){1'b0}}, f_dim};

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    kp = ({1'b0, kpos} >= klim) ? '0 : kpos;
    kn = {1'b0, kp} + 1'b1;
    fp = ({1'b0, fpos} >= flim) ? '0 : fpos;
    fn = {1'b0, fp} + 1'b1;
    xp = ({1'b0, xpos} >= flim) ? '0 : xpos;
    xn = {1'b0, xp} + 1'b1;

    kpos_next  = kpos;
    fpos_next  = fpos;
    xpos_next  = xpos;
    push       = 1'b0;
    job.kind   = JOB_FETCH;
    job.addr   = '0;
    job.value  = item.value;
    job.last   = 1'b0;
    job.empty  = 1'b0;

    case (cmd_t'(item.cmd))
      CMD_KEY_LOAD: begin
        push      = accept;
        job.kind  = JOB_KEY;
        job.addr  = FILE_AW'(kp);
        kpos_next = (kn >= klim) ? '0 : kn[KEY_AW-1:0];
      end
      CMD_FILE_LOAD: begin
        push      = accept;
        job.kind  = JOB_FILE;
        job.addr  = fp;
        fpos_next = (fn >= flim) ? '0 : fn[FILE_AW-1:0];
      end
      CMD_FETCH: begin
        push      = accept;
        job.kind  = JOB_FETCH;
        job.addr  = xp;
        job.empty = (flim == '0);
        job.last  = (xn >= flim);
        xpos_next = (xn >= flim) ? '0 : xn[FILE_AW-1:0];
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kpos <= '0;
      fpos <= '0;
      xpos <= '0;
    end else if (accept) begin
      kpos <= kpos_next;
      fpos <= fpos_next;
      xpos <= xpos_next;
    end
  end

endmodule

@@ sv/tkmm_queue.sv @@
`timescale 1ns / 1ps

module tkmm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tkmm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tkmm_pkg::job_t head
);
  import tkmm_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_pop;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/tkmm_back.sv @@
`timescale 1ns / 1ps

module tkmm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  tkmm_pkg::job_t                  job,
  output logic                            job_pop,
  input  logic [tkmm_pkg::KEY_DIM_W-1:0]  k_dim,
  input  logic [tkmm_pkg::FILE_DIM_W-1:0] f_dim,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tkmm_pkg::result_t               result
);
  import tkmm_pkg::*;

  back_state_t state, state_next;

  logic signed [VALUE_W-1:0] key_mem  [KEY_DEPTH];
  logic signed [VALUE_W-1:0] file_mem [FILE_DEPTH];
  logic signed [VALUE_W-1:0] key_q, file_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RESULT_W-1:0] acc;

  // shared restoring divider
  logic [11:0] rem, rem_new;
  logic [6:0]  den;
  logic [5:0]  quo, quo_new;
  logic [2:0]  step;
  logic [12:0] trial;
  logic        ge, div_last;

  logic [5:0]  row, col;
  logic [3:0]  span_q;
  logic [9:0]  span;
  logic [4:0]  kr;
  logic [5:0]  row0;
  logic [12:0] file_base;
  logic [10:0] key_base;
  logic        in_tile, last_flag;

  logic [KEY_AW-1:0]  key_addr;
  logic [FILE_AW-1:0] file_addr;
  logic [4:0]         cnt;
  logic               rd_v, mul_v;

  logic fetch_start, fetch_zero, mac_done;
  logic key_we, file_we, ld_rowcol, ld_span, ld_band, div_run;
  logic mac_issue, out_load, base_load;

  assign trial     = {6'd0, den} << step;
  assign ge        = ({1'b0, rem} >= trial);
  assign rem_new   = ge ? (rem - trial[11:0]) : rem;
  assign div_last  = (step == 3'd0);
  assign span      = {6'd0, span_q} * {4'd0, k_dim};
  assign in_tile   = ({4'd0, row} < span) && ({4'd0, col} < span);
  assign row0      = row - {1'b0, kr};
  assign file_base = {7'd0, row0} * {6'd0, f_dim} + {7'd0, col};
  assign key_base  = {6'd0, kr} * {5'd0, k_dim};
  assign mac_done  = ({1'b0, cnt} == (k_dim - 6'd1));

  always_comb begin
    quo_new = quo;
    if (ge) begin
      quo_new[step] = 1'b1;
    end
  end

  assign fetch_start = (state == BK_IDLE) && job_valid && (job.kind == JOB_FETCH);
  assign fetch_zero  = job.empty || (k_dim == '0);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (fetch_start) begin
          state_next = fetch_zero ? BK_OUT : BK_ROWCOL;
        end
      end
      BK_ROWCOL: if (div_last) state_next = BK_SPAN;
      BK_SPAN:   if (div_last) state_next = BK_CHECK;
      BK_CHECK:  state_next = in_tile ? BK_BAND : BK_OUT;
      BK_BAND:   if (div_last) state_next = BK_BASE;
      BK_BASE:   state_next = BK_MAC;
      BK_MAC:    if (mac_done) state_next = BK_DRAIN;
      BK_DRAIN:  if (!rd_v && !mul_v) state_next = BK_OUT;
      BK_OUT:    if (!result_valid || result_ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    key_we    = 1'b0;
    file_we   = 1'b0;
    ld_rowcol = 1'b0;
    ld_span   = 1'b0;
    ld_band   = 1'b0;
    div_run   = 1'b0;
    base_load = 1'b0;
    mac_issue = 1'b0;
    out_load  = 1'b0;
    case (state)
      BK_IDLE: begin
        job_pop   = job_valid;
        key_we    = job_valid && (job.kind == JOB_KEY);
        file_we   = job_valid && (job.kind == JOB_FILE);
        ld_rowcol = fetch_start && !fetch_zero;
      end
      BK_ROWCOL: begin
        div_run = 1'b1;
        ld_span = div_last;
      end
      BK_SPAN:  div_run = 1'b1;
      BK_CHECK: ld_band = in_tile;
      BK_BAND:  div_run = 1'b1;
      BK_BASE:  base_load = 1'b1;
      BK_MAC:   mac_issue = 1'b1;
      BK_OUT:   out_load = !result_valid || result_ready;
      default:  job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[job.addr[KEY_AW-1:0]] <= job.value;
    end
    key_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (file_we) begin
      file_mem[job.addr] <= job.value;
    end
    file_q <= file_mem[file_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_rowcol) begin
      rem  <= job.addr;
      den  <= f_dim;
      quo  <= '0;
      step <= 3'd5;
    end else if (ld_span) begin
      rem  <= {5'd0, f_dim};
      den  <= {1'b0, k_dim};
      quo  <= '0;
      step <= 3'd3;
    end else if (ld_band) begin
      rem  <= {6'd0, row};
      den  <= {1'b0, k_dim};
      quo  <= '0;
      step <= 3'd2;
    end else if (div_run) begin
      rem  <= rem_new;
      quo  <= quo_new;
      step <= step - 3'd1;
    end

    if (state == BK_ROWCOL && div_last) begin
      row <= quo_new;
      col <= rem_new[5:0];
    end
    if (state == BK_SPAN && div_last) begin
      span_q <= quo_new[3:0];
    end
    if (state == BK_BAND && div_last) begin
      kr <= rem_new[4:0];
    end
    if (fetch_start) begin
      last_flag <= job.last;
    end

    if (base_load) begin
      key_addr  <= key_base[KEY_AW-1:0];
      file_addr <= file_base[FILE_AW-1:0];
      cnt       <= '0;
    end else if (mac_issue) begin
      key_addr  <= key_addr + 1'b1;
      file_addr <= file_addr + {{(FILE_AW-FILE_DIM_W){1'b0}}, f_dim};
      cnt       <= cnt + 1'b1;
    end

    prod <= key_q * file_q;
    if (fetch_start) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + RESULT_W'(prod);
    end

    if (out_load) begin
      result.result_value <= acc;
      result.last         <= last_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v         <= 1'b0;
      mul_v        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_v  <= mac_issue;
      mul_v <= rd_v;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/tiled_key_matrix_multiply.sv @@
`timescale 1ns / 1ps
// Loads are written from the back end's idle state; a fetch runs through row/column
// divide, span divide, tile check, band divide, base, K multiply-accumulates, drain
// and output (a zero-size or out-of-tile fetch skips to output) before the next job.
// A 4-entry queue lets loads and fetches transfer while the back end is busy.
// Synchronous active-high reset clears positions and control; key_dim resets to 8,
// file_dim to 64; key and file stores are undefined until written.

module tiled_key_matrix_multiply (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  tkmm_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tkmm_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tkmm_pkg::FILE_DIM_W-1:0]  cfg_data
);
  import tkmm_pkg::*;

  logic [KEY_DIM_W-1:0]  key_dim, k_eff;
  logic [FILE_DIM_W-1:0] file_dim, f_eff;
  logic                  queue_full, push, head_valid, pop;
  job_t                  push_job, head;

  assign cfg_ready = 1'b1;
  assign k_eff     = eff_key(key_dim);
  assign f_eff     = eff_file(file_dim);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_dim  <= KEY_DIM_W'(8);
      file_dim <= FILE_DIM_W'(64);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_DIM:  key_dim  <= cfg_data[KEY_DIM_W-1:0];
        CFG_FILE_DIM: file_dim <= cfg_data;
        default:      file_dim <= file_dim;
      endcase
    end
  end

  tkmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .k_dim      (k_eff),
    .f_dim      (f_eff),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  tkmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tkmm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job          (head),
    .job_pop      (pop),
    .k_dim        (k_eff),
    .f_dim        (f_eff),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tkmm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [FILE_DIM_W-1:0] cfg_data = '0;

  tiled_key_matrix_multiply u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block state
  logic signed [VALUE_W-1:0] key_mirror [KEY_DEPTH];
  logic signed [VALUE_W-1:0] file_mirror [FILE_DEPTH];
  bit key_written [KEY_DEPTH];
  bit file_written [FILE_DEPTH];
  logic [KEY_DIM_W-1:0]  key_side  = KEY_DIM_W'(8);
  logic [FILE_DIM_W-1:0] file_side = FILE_DIM_W'(64);
  int unsigned key_wr = 0;
  int unsigned file_wr = 0;
  int unsigned fetch_idx = 0;

  result_t expected_cells [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  function automatic bit stall_roll();
    return !no_idle && ($urandom_range(99) < 33);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  function automatic int unsigned key_tile();
    int unsigned k;
    k = key_side;
    if (k > MAX_KEY_DIM) k = MAX_KEY_DIM;
    return k - (k % TILE_ALIGN);
  endfunction

  function automatic int unsigned file_edge();
    int unsigned f;
    f = file_side;
    if (f > MAX_FILE_DIM) f = MAX_FILE_DIM;
    return f;
  endfunction

  // fetches may only touch loaded entries
  function automatic bit stores_ready(int unsigned k, int unsigned f);
    if (k == 0 || k > f) return 1'b1;
    for (int unsigned i = 0; i < k * k; i++) begin
      if (!key_written[i]) return 1'b0;
    end
    for (int unsigned i = 0; i < f * f; i++) begin
      if (!file_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint tile_dot(int unsigned row, int unsigned col,
                                      int unsigned k, int unsigned f);
    int unsigned span;
    int unsigned band;
    int unsigned kr;
    longint acc;
    acc = 0;
    if (k == 0) return 0;
    span = (f / k) * k;
    if (row >= span || col >= span) return 0;
    band = row / k;
    kr = row % k;
    for (int unsigned j = 0; j < k; j++) begin
      acc += longint'(key_mirror[(kr * k + j) % KEY_DEPTH]) *
             longint'(file_mirror[((band * k + j) * f + col) % FILE_DEPTH]);
    end
    return acc;
  endfunction

  task automatic predict_item(input item_t it);
    int unsigned k;
    int unsigned f;
    int unsigned lim;
    longint acc;
    result_t pred;
    k = key_tile();
    f = file_edge();
    case (cmd_t'(it.cmd))
      CMD_KEY_LOAD: begin
        lim = k * k;
        if (key_wr >= lim) key_wr = 0;
        key_mirror[key_wr % KEY_DEPTH] = it.value;
        key_written[key_wr % KEY_DEPTH] = 1'b1;
        key_wr++;
        if (key_wr >= lim) key_wr = 0;
      end
      CMD_FILE_LOAD: begin
        lim = f * f;
        if (file_wr >= lim) file_wr = 0;
        file_mirror[file_wr % FILE_DEPTH] = it.value;
        file_written[file_wr % FILE_DEPTH] = 1'b1;
        file_wr++;
        if (file_wr >= lim) file_wr = 0;
      end
      CMD_FETCH: begin
        lim = f * f;
        if (lim == 0) begin
          fetch_idx = 0;
          pred.result_value = '0;
          pred.last = 1'b1;
        end else begin
          if (fetch_idx >= lim) fetch_idx = 0;
          acc = tile_dot(fetch_idx / f, fetch_idx % f, k, f);
          pred.result_value = acc[RESULT_W-1:0];
          fetch_idx++;
          pred.last = (fetch_idx >= lim);
          if (fetch_idx >= lim) fetch_idx = 0;
        end
        expected_cells.push_back(pred);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input cmd_t cmd, input logic signed [VALUE_W-1:0] value);
    item_t it;
    it.cmd = cmd;
    it.value = value;
    @(negedge clk);
    while (stall_roll()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    predict_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [FILE_DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_KEY_DIM) key_side = data[KEY_DIM_W-1:0];
    else file_side = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input logic [FILE_DIM_W-1:0] kd,
                             input logic [FILE_DIM_W-1:0] fd);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_KEY_DIM, kd);
    write_reg(CFG_FILE_DIM, fd);
  endtask

  always @(negedge clk) result_ready <= !stall_roll();

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_cells.size() == 0) begin
        $error("result transfer with no cell pending: result_value %0d last %0b",
               result.result_value, result.last);
        errors++;
      end else begin
        result_t want;
        want = expected_cells.pop_front();
        if (result.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 want.result_value, result.result_value);
          errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, result.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_idle_commands();
    send_item(CMD_NONE, 16'sh8000);
    send_item(CMD_NONE, 16'sh7FFF);
  endtask

  task automatic test_empty_file();
    reconfigure(7'd8, 7'd0);
    send_item(CMD_FILE_LOAD, 16'sh7FFF);
    repeat (2) send_item(CMD_FETCH, pick_value());
  endtask

  task automatic test_empty_key();
    reconfigure(7'd7, 7'd127);
    send_item(CMD_KEY_LOAD, 16'sh8000);
    repeat (3) send_item(CMD_FETCH, pick_value());
  endtask

  task automatic test_key_wider_than_file();
    reconfigure(7'd63, 7'd9);
    send_item(CMD_KEY_LOAD, 16'sh8000);
    send_item(CMD_KEY_LOAD, 16'sh7FFF);
    send_item(CMD_KEY_LOAD, 16'sh0000);
    send_item(CMD_KEY_LOAD, 16'shFFFF);
    repeat (4) send_item(CMD_FETCH, pick_value());
  endtask

  // extreme entries over a full 8 by 8 shape; fetches sweep the whole matrix
  task automatic test_full_scale_sums();
    no_idle = 1'b1;
    reconfigure(7'd8, 7'd8);
    repeat (64) send_item(CMD_KEY_LOAD, 16'sh8000);
    repeat (64) send_item(CMD_FILE_LOAD, file_wr[0] ? 16'sh7FFF : 16'sh8000);
    repeat (64) send_item(CMD_FETCH, pick_value());
    no_idle = 1'b0;
  endtask

  task automatic test_random_tiles();
    int unsigned sent;
    int unsigned k;
    int unsigned f;
    int unsigned n;
    int unsigned pick;
    logic [FILE_DIM_W-1:0] kd;
    logic [FILE_DIM_W-1:0] fd;
    cmd_t noise;
    bit first;
    sent = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 5) kd = 7'd8;
      else if (pick < 7) kd = 7'd16;
      else if (pick == 7) kd = $urandom_range(1) ? 7'd24 : 7'd32;
      else kd = FILE_DIM_W'($urandom_range(0, 63));
      pick = $urandom_range(9);
      if (pick < 7) fd = FILE_DIM_W'($urandom_range(8, 16));
      else if (pick == 7) fd = FILE_DIM_W'($urandom_range(17, 40));
      else if (pick == 8) fd = FILE_DIM_W'($urandom_range(64, 127));
      else fd = FILE_DIM_W'($urandom_range(0, 127));
      reconfigure(kd, fd);
      no_idle = first;
      k = key_tile();
      f = file_edge();
      if (k != 0 && k <= 16 && (!stores_ready(k, f) || $urandom_range(1))) begin
        repeat (k * k) begin
          send_item(CMD_KEY_LOAD, pick_value());
          sent++;
        end
      end
      if (f <= 16 && (!stores_ready(k, f) || $urandom_range(1))) begin
        repeat (f * f) begin
          send_item(CMD_FILE_LOAD, pick_value());
          sent++;
        end
      end
      n = (f <= 10 && $urandom_range(1)) ? f * f : $urandom_range(20, 60);
      if (n == 0) n = 4;
      if (!stores_ready(k, f)) n = 0;
      repeat (n) begin
        if ($urandom_range(9) == 0) begin
          noise = cmd_t'($urandom_range(3));
          send_item(noise, pick_value());
          if (noise != CMD_NONE) sent++;
        end
        send_item(CMD_FETCH, pick_value());
        sent++;
        if ($urandom_range(63) == 0) drain_results();
      end
      no_idle = 1'b0;
      first = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_empty_file();
    test_empty_key();
    test_key_wider_than_file();
    test_full_scale_sums();
    test_random_tiles();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
